>>> hw/rtl/rwlm_pkg.sv
// Package for the reader-writer lock manager: defaults, codes and the sequencer state type.
`default_nettype none
package rwlm_pkg;

    localparam int NUM_LOCKS_DEF   = 64;
    localparam int MAX_HOLDERS_DEF = 8;
    localparam int WAIT_DEPTH_DEF  = 8;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    localparam logic [1:0] ACT_LOCK_RD = 2'd0;
    localparam logic [1:0] ACT_LOCK_WR = 2'd1;
    localparam logic [1:0] ACT_REL_RD  = 2'd2;
    localparam logic [1:0] ACT_REL_WR  = 2'd3;

    localparam logic [1:0] MODE_UNLOCKED = 2'd0;
    localparam logic [1:0] MODE_READ     = 2'd1;
    localparam logic [1:0] MODE_WRITE    = 2'd2;
    localparam logic [1:0] MODE_RW       = 2'd3;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_QUEUED   = 3'd1;
    localparam logic [2:0] ST_RELEASED = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_QFULL    = 3'd4;
    localparam logic [2:0] ST_HFULL    = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LRD,
        S_HSCAN,
        S_DECIDE,
        S_PR_RD,
        S_PR_CHK,
        S_POST,
        S_QSCAN,
        S_QDEC,
        S_HWR,
        S_WB
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/reader_writer_lock_manager_top.sv
// Top level of the reader-writer lock manager: lock table sequencer over two RAMs.
//
//  channel   direction  signals                                       beat when
//  request   in         start, busy, i_action, i_lock_index,          start && !busy
//                       i_requester_id, i_now_us
//  result    out        o_strobe, o_granted, o_status, o_mode_after   o_strobe (one cycle)
//  config    in         i_cfg_valid, o_cfg_ready, i_cfg_data          i_cfg_valid && o_cfg_ready
//
// One request at a time; the lock record read is followed by a scan of every holder slot.
// An inspected queue has its aged waiters pruned from the head and its head checked, then the
// queued waiters are scanned for a duplicate, and a slot write may follow.
// The single read port of the slot RAM sets the pace: slots are examined one at a time.
// After reset a clearing pass writes every lock record, with busy high.
// The result is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module reader_writer_lock_manager_top #(
    parameter int NUM_LOCKS   = rwlm_pkg::NUM_LOCKS_DEF,
    parameter int MAX_HOLDERS = rwlm_pkg::MAX_HOLDERS_DEF,
    parameter int WAIT_DEPTH  = rwlm_pkg::WAIT_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [5:0]  i_lock_index,
    input  wire logic [15:0] i_requester_id,
    input  wire logic [31:0] i_now_us,
    output logic             o_strobe,
    output logic             o_granted,
    output logic [2:0]       o_status,
    output logic [1:0]       o_mode_after,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    import rwlm_pkg::*;

    localparam int LW   = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int HW   = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
    localparam int QW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW   = $clog2(WAIT_DEPTH + 1);
    localparam int SW   = (HW > QW) ? HW : QW;
    localparam int IW   = SW + 1;
    localparam int PW   = CW + 1;
    localparam int RECW = MAX_HOLDERS + CW + QW + 2;
    localparam int SAW  = LW + 1 + SW;
    localparam int SDW  = 49;

    // Lock record layout: {holder valid bits, count, head, mode}.
    localparam int OFS_HEAD = 2;
    localparam int OFS_CNT  = 2 + QW;
    localparam int OFS_HV   = 2 + QW + CW;

    t_state r_state, n_state;

    logic [31:0]            r_timeout;
    logic [LW-1:0]          r_clr;
    logic [LW-1:0]          r_lk;
    logic [1:0]             r_action;
    logic [15:0]            r_id;
    logic [31:0]            r_now;
    logic                   r_wr;
    logic [1:0]             r_mode;
    logic [QW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic [MAX_HOLDERS-1:0] r_hval;
    logic [SW-1:0]          r_idx;
    logic                   r_hfound;
    logic [HW-1:0]          r_hslot;
    logic                   r_ffound;
    logic [HW-1:0]          r_ffree;
    logic                   r_tryacq;
    logic [15:0]            r_hd_id;
    logic                   r_hd_wr;
    logic [2:0]             r_st;
    logic                   r_o_strobe;
    logic                   r_o_granted;
    logic [2:0]             r_o_status;
    logic [1:0]             r_o_mode;

    logic            lk_we;
    logic [LW-1:0]   lk_waddr;
    logic [RECW-1:0] lk_wdata;
    logic [LW-1:0]   lk_raddr;
    logic [RECW-1:0] lk_rdata;
    logic            sl_we;
    logic [SAW-1:0]  sl_waddr;
    logic [SDW-1:0]  sl_wdata;
    logic [SAW-1:0]  sl_raddr;
    logic [SDW-1:0]  sl_rdata;

    logic            accept;
    logic            in_range;
    logic            hscan_last;
    logic            qscan_last;
    logic            slot_valid;
    logic            aged;
    logic            head_match;
    logic            qfull;
    logic [QW-1:0]   q_first;
    logic [QW-1:0]   q_next;
    logic [QW-1:0]   q_tail;
    logic [QW-1:0]   head_inc;

    // Ring position of entry pos counted from the head; pos never exceeds the depth.
    function automatic logic [QW-1:0] slot_of(input logic [QW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [PW-1:0] sum;
        sum = PW'(head) + PW'(pos);
        if (sum >= PW'(WAIT_DEPTH)) begin
            sum = sum - PW'(WAIT_DEPTH);
        end
        return sum[QW-1:0];
    endfunction

    assign accept      = start && !busy;
    assign in_range    = 32'(i_lock_index) < 32'(NUM_LOCKS);
    assign hscan_last  = r_idx == SW'(MAX_HOLDERS - 1);
    assign qscan_last  = IW'(r_idx) + IW'(1) == IW'(r_count);
    assign slot_valid  = r_hval[r_idx[HW-1:0]];
    assign aged        = (r_now - sl_rdata[31:0]) > r_timeout;
    assign head_match  = r_hd_id == r_id;
    assign qfull       = r_count == CW'(WAIT_DEPTH);
    assign q_first     = slot_of(r_head, CW'(0));
    assign q_next      = slot_of(r_head, CW'(IW'(r_idx) + IW'(1)));
    assign q_tail      = slot_of(r_head, r_count);
    assign head_inc    = slot_of(r_head, CW'(1));

    assign busy        = r_state != S_IDLE;
    // The timeout is only taken between requests, so a prune never sees it change.
    assign o_cfg_ready = !busy;
    assign o_strobe    = r_o_strobe;
    assign o_granted   = r_o_granted;
    assign o_status    = r_o_status;
    assign o_mode_after = r_o_mode;

    rwlm_ram #(.WIDTH(RECW), .DEPTH(NUM_LOCKS), .AW(LW)) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    rwlm_ram #(.WIDTH(SDW), .DEPTH(2 ** SAW), .AW(SAW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (sl_wdata),
        .i_raddr (sl_raddr),
        .o_rdata (sl_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LW'(NUM_LOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && in_range) begin
                    n_state = S_LRD;
                end
            end
            S_LRD: n_state = S_HSCAN;
            S_HSCAN: begin
                if (hscan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_action)
                    ACT_LOCK_RD: begin
                        if (r_mode == MODE_UNLOCKED) begin
                            n_state = S_PR_RD;
                        end else if (r_hfound) begin
                            n_state = S_WB;
                        end else if (r_mode == MODE_READ) begin
                            n_state = S_PR_RD;
                        end else begin
                            n_state = (r_count != '0) ? S_QSCAN : S_QDEC;
                        end
                    end
                    ACT_LOCK_WR: begin
                        if (r_mode == MODE_UNLOCKED) begin
                            n_state = S_PR_RD;
                        end else if (r_hfound && (r_mode != MODE_READ || $onehot(r_hval))) begin
                            n_state = S_WB;
                        end else begin
                            n_state = (r_count != '0) ? S_QSCAN : S_QDEC;
                        end
                    end
                    default: n_state = S_WB;
                endcase
            end
            S_PR_RD: n_state = (r_count != '0) ? S_PR_CHK : S_POST;
            S_PR_CHK: n_state = aged ? S_PR_RD : S_POST;
            S_POST: begin
                if (r_tryacq) begin
                    if (r_count == '0 || head_match) begin
                        n_state = S_HWR;
                    end else begin
                        n_state = S_QSCAN;
                    end
                end else if (r_count != '0 && r_hd_wr) begin
                    n_state = S_QSCAN;
                end else begin
                    n_state = r_ffound ? S_HWR : S_WB;
                end
            end
            S_QSCAN: begin
                if (sl_rdata[48:33] == r_id) begin
                    n_state = S_WB;
                end else if (qscan_last) begin
                    n_state = S_QDEC;
                end
            end
            S_QDEC: n_state = S_WB;
            S_HWR: n_state = S_WB;
            S_WB: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port control.
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = r_lk;
        lk_wdata = {r_hval, r_count, r_head, r_mode};
        lk_raddr = LW'(i_lock_index);
        sl_we    = 1'b0;
        sl_waddr = {r_lk, 1'b0, SW'(r_hslot)};
        sl_wdata = {r_id, r_wr, r_now};
        sl_raddr = {r_lk, 1'b1, SW'(q_first)};
        case (r_state)
            S_CLEAR: begin
                lk_we    = 1'b1;
                lk_waddr = r_clr;
                lk_wdata = '0;
            end
            S_LRD: sl_raddr = {r_lk, 1'b0, SW'(0)};
            S_HSCAN: sl_raddr = {r_lk, 1'b0, r_idx + SW'(1)};
            S_QSCAN: sl_raddr = {r_lk, 1'b1, SW'(q_next)};
            S_QDEC: begin
                sl_we    = !qfull;
                sl_waddr = {r_lk, 1'b1, SW'(q_tail)};
            end
            S_HWR: begin
                sl_we    = 1'b1;
                sl_wdata = {r_id, 33'd0};
            end
            S_WB: lk_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_timeout  <= TIMEOUT_RESET;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + LW'(1);
            end
            if (r_state == S_WB || (accept && !in_range)) begin
                r_o_strobe <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lk     <= LW'(i_lock_index);
                r_action <= i_action;
                r_id     <= i_requester_id;
                r_now    <= i_now_us;
                r_wr     <= i_action == ACT_LOCK_WR;
                if (accept && !in_range) begin
                    r_o_granted <= 1'b0;
                    r_o_status  <= (i_action == ACT_LOCK_RD || i_action == ACT_LOCK_WR) ?
                                   ST_QFULL : ST_IGNORED;
                    r_o_mode    <= MODE_UNLOCKED;
                end
            end
            S_LRD: begin
                r_mode   <= lk_rdata[1:0];
                r_head   <= lk_rdata[OFS_HEAD +: QW];
                r_count  <= lk_rdata[OFS_CNT +: CW];
                r_hval   <= lk_rdata[OFS_HV +: MAX_HOLDERS];
                r_idx    <= '0;
                r_hfound <= 1'b0;
                r_ffound <= 1'b0;
            end
            S_HSCAN: begin
                r_idx <= r_idx + SW'(1);
                if (slot_valid && sl_rdata[48:33] == r_id && !r_hfound) begin
                    r_hfound <= 1'b1;
                    r_hslot  <= r_idx[HW-1:0];
                end
                if (!slot_valid && !r_ffound) begin
                    r_ffound <= 1'b1;
                    r_ffree  <= r_idx[HW-1:0];
                end
            end
            S_DECIDE: begin
                r_idx    <= '0;
                r_tryacq <= r_mode == MODE_UNLOCKED;
                r_st     <= ST_IGNORED;
                case (r_action)
                    ACT_LOCK_RD: begin
                        if (r_mode != MODE_UNLOCKED && r_hfound) begin
                            r_st <= ST_GRANTED;
                            if (r_mode != MODE_READ) begin
                                r_mode <= MODE_RW;
                            end
                        end
                    end
                    ACT_LOCK_WR: begin
                        if (r_mode == MODE_READ && r_hfound && $onehot(r_hval)) begin
                            r_mode <= MODE_RW;
                            r_st   <= ST_GRANTED;
                        end else if (r_mode != MODE_UNLOCKED && r_mode != MODE_READ &&
                                     r_hfound) begin
                            r_st <= ST_GRANTED;
                        end
                    end
                    ACT_REL_RD: begin
                        if (r_hfound && r_mode == MODE_READ) begin
                            r_hval <= r_hval & ~(MAX_HOLDERS'(1) << r_hslot);
                            if ((r_hval & ~(MAX_HOLDERS'(1) << r_hslot)) == '0) begin
                                r_mode <= MODE_UNLOCKED;
                            end
                            r_st <= ST_RELEASED;
                        end else if (r_hfound && r_mode == MODE_RW) begin
                            r_mode <= MODE_WRITE;
                            r_st   <= ST_RELEASED;
                        end
                    end
                    default: begin
                        if (r_hfound && r_mode == MODE_WRITE) begin
                            r_hval <= '0;
                            r_mode <= MODE_UNLOCKED;
                            r_st   <= ST_RELEASED;
                        end else if (r_hfound && r_mode == MODE_RW) begin
                            r_mode <= MODE_READ;
                            r_st   <= ST_RELEASED;
                        end
                    end
                endcase
            end
            S_PR_CHK: begin
                if (aged) begin
                    r_head  <= head_inc;
                    r_count <= r_count - CW'(1);
                end else begin
                    r_hd_id <= sl_rdata[48:33];
                    r_hd_wr <= sl_rdata[32];
                end
            end
            S_POST: begin
                r_idx <= '0;
                if (r_tryacq) begin
                    if (r_count == '0 || head_match) begin
                        if (r_count != '0) begin
                            r_head  <= head_inc;
                            r_count <= r_count - CW'(1);
                        end
                        r_mode  <= r_wr ? MODE_WRITE : MODE_READ;
                        r_hval  <= MAX_HOLDERS'(1);
                        r_hslot <= '0;
                        r_st    <= ST_GRANTED;
                    end
                end else if (!(r_count != '0 && r_hd_wr)) begin
                    if (r_ffound) begin
                        r_hval  <= r_hval | (MAX_HOLDERS'(1) << r_ffree);
                        r_hslot <= r_ffree;
                        r_st    <= ST_GRANTED;
                    end else begin
                        r_st <= ST_HFULL;
                    end
                end
            end
            S_QSCAN: begin
                r_idx <= r_idx + SW'(1);
                if (sl_rdata[48:33] == r_id) begin
                    r_st <= ST_QUEUED;
                end
            end
            S_QDEC: begin
                if (qfull) begin
                    r_st <= ST_QFULL;
                end else begin
                    r_count <= r_count + CW'(1);
                    r_st    <= ST_QUEUED;
                end
            end
            S_WB: begin
                r_o_granted <= r_st == ST_GRANTED;
                r_o_status  <= r_st;
                r_o_mode    <= r_mode;
            end
            default: begin
            end
        endcase
    end

    // A result appears only after a write-back or an out-of-range request.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_WB) || $past(start && !busy))
        else $error("result strobe without a finished request");

    a_granted_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_granted == (o_status == ST_GRANTED)))
        else $error("granted flag disagrees with status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (r_count <= CW'(WAIT_DEPTH)))
        else $error("wait queue count beyond depth");

endmodule
`default_nettype wire

>>> hw/rtl/rwlm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rwlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
